// ===== hdl/vl2n_pkg.sv =====
// Shared types and constants for the vector L2 normalization block.
`timescale 1ns / 1ps

package vl2n_pkg;

    // Width of the norm floor configuration register.
    localparam int FLOOR_W = 19;
    // Width of a normalized result element (Q1.15).
    localparam int OUT_W = 16;
    // Fraction bits of the Q1.15 result.
    localparam int FRAC_SHIFT = 15;
    // Quotient register width: the sixteen result bits plus one saturation guard bit.
    localparam int QUO_W = OUT_W + 1;

    localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'(32767);
    localparam logic [QUO_W-1:0] Q_NEG_MAX = QUO_W'(32768);
    localparam logic [OUT_W-1:0] VAL_POS_SAT = 16'h7FFF;
    localparam logic [OUT_W-1:0] VAL_NEG_SAT = 16'h8000;

    // Controller states, one-hot.
    typedef enum logic [9:0] {
        S_LOAD   = 10'b0000000001,
        S_SUM    = 10'b0000000010,
        S_SQINIT = 10'b0000000100,
        S_SQRT   = 10'b0000001000,
        S_NORM   = 10'b0000010000,
        S_READ   = 10'b0000100000,
        S_DIVLD  = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_SAT    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take one input element
        logic sqrt_start;  // load the square sum into the root unit
        logic sqrt_step;   // one root digit
        logic norm_latch;  // pick the divisor, restart the read index
        logic mem_read;    // read the element at the read index
        logic div_start;   // load the divider from the read element
        logic div_step;    // one quotient bit
        logic out_load;    // saturate and register the result
        logic next_elem;   // advance the read index
        logic clear;       // end of vector, clear count, sum and flag
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic is_last_elem;
    } sts_t;

endpackage

// ===== hdl/vl2n_ctrl.sv =====
// Controller state machine for the vector L2 normalization block.
`timescale 1ns / 1ps

module vl2n_ctrl
    import vl2n_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last,
    input  logic out_stall,
    input  sts_t sts,
    output logic in_stall,
    output logic out_valid,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                // The square of the final element lands in the sum here.
                state_next = S_SQINIT;
            end
            S_SQINIT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.norm_latch = 1'b1;
                state_next     = S_READ;
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_DIVLD;
            end
            S_DIVLD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                // The final quotient bit is in place; register the saturated result.
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (sts.is_last_elem)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.next_elem = 1'b1;
                        state_next    = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ===== hdl/vl2n_datapath.sv =====
// Datapath: element store, square sum, square root unit and serial divider.
`timescale 1ns / 1ps

module vl2n_datapath
    import vl2n_pkg::*;
#(
    parameter int MAX_LEN     = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output sts_t                          sts,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          cfg_wr_en,
    input  logic [FLOOR_W-1:0]            cfg_wr_data,
    output logic signed [OUT_W-1:0]       unit_value,
    output logic                          last_res,
    output logic                          overflow
);

    localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int SQ_PROD  = 2 * SAMPLE_BITS;
    localparam int SUM_RAW  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_LEN);
    localparam int SQ_W     = ((SUM_RAW + 1) / 2) * 2;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int NORM_W   = (ROOT_W > FLOOR_W) ? ROOT_W : FLOOR_W;
    localparam int DIV_W    = SAMPLE_BITS + FRAC_SHIFT;
    localparam int MAX_STEP = (ROOT_W > DIV_W) ? ROOT_W : DIV_W;
    localparam int STEP_W   = $clog2(MAX_STEP);

    // Element store, no reset: only entries of the current vector are read.
    logic [SAMPLE_BITS-1:0] mem [MAX_LEN];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               overflowed_reg;
    logic [SQ_PROD-1:0] sq_reg;
    logic               sq_vld_reg;
    logic [SQ_W-1:0]    sum_reg;
    logic [FLOOR_W-1:0] floor_reg;

    logic [SQ_W-1:0]     sq_x_reg;
    logic [ROOT_W+1:0]   sq_rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [NORM_W-1:0]   norm_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [DIV_W-1:0]    dvd_reg;
    logic [NORM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]    q_reg;
    logic                sat_reg;
    logic                neg_reg;

    logic [SAMPLE_BITS-1:0] in_mag;
    logic [SAMPLE_BITS-1:0] rd_mag;
    logic [ROOT_W+1:0]      sq_rem_sh;
    logic [ROOT_W+1:0]      sq_trial;
    logic                   sq_ge;
    logic [NORM_W:0]        div_rem_sh;
    logic [NORM_W:0]        div_diff;
    logic                   div_ge;
    logic [FLOOR_W-1:0]     floor_eff;
    logic [NORM_W-1:0]      root_ext;
    logic [NORM_W-1:0]      floor_ext;
    logic [OUT_W-1:0]       val;

    assign in_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign rd_mag = rd_data_reg[SAMPLE_BITS-1] ? (~rd_data_reg + 1'b1) : rd_data_reg;

    assign sq_rem_sh = {sq_rem_reg[ROOT_W-1:0], sq_x_reg[SQ_W-1 -: 2]};
    assign sq_trial  = {root_reg, 2'b01};
    assign sq_ge     = (sq_rem_sh >= sq_trial);

    assign div_rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_diff   = div_rem_sh - {1'b0, norm_reg};
    assign div_ge     = (div_rem_sh >= {1'b0, norm_reg});

    assign floor_eff = (floor_reg == '0) ? FLOOR_W'(1) : floor_reg;
    assign root_ext  = NORM_W'(root_reg);
    assign floor_ext = NORM_W'(floor_eff);

    assign sts.sqrt_done    = (step_reg == STEP_W'(ROOT_W - 1));
    assign sts.div_done     = (step_reg == STEP_W'(DIV_W - 1));
    assign sts.is_last_elem = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        if (neg_reg)
        begin
            if (sat_reg || (q_reg > Q_NEG_MAX))
            begin
                val = VAL_NEG_SAT;
            end
            else
            begin
                val = ~q_reg[OUT_W-1:0] + 1'b1;
            end
        end
        else
        begin
            if (sat_reg || (q_reg > Q_POS_MAX))
            begin
                val = VAL_POS_SAT;
            end
            else
            begin
                val = q_reg[OUT_W-1:0];
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CNT_W'(MAX_LEN)))
        begin
            mem[count_reg[IDX_W-1:0]] <= sample;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            overflowed_reg <= 1'b0;
            sq_vld_reg     <= 1'b0;
            sum_reg        <= '0;
            floor_reg      <= FLOOR_W'(1);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                floor_reg <= cfg_wr_data;
            end
            sq_vld_reg <= 1'b0;
            if (cmd.load)
            begin
                if (count_reg < CNT_W'(MAX_LEN))
                begin
                    count_reg  <= count_reg + 1'b1;
                    sq_vld_reg <= 1'b1;
                end
                else
                begin
                    overflowed_reg <= 1'b1;
                end
            end
            if (sq_vld_reg)
            begin
                sum_reg <= sum_reg + SQ_W'(sq_reg);
            end
            if (cmd.clear)
            begin
                count_reg      <= '0;
                overflowed_reg <= 1'b0;
                sum_reg        <= '0;
            end
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_reg <= in_mag * in_mag;
        end
        if (cmd.sqrt_start)
        begin
            sq_x_reg   <= sum_reg;
            sq_rem_reg <= '0;
            root_reg   <= '0;
            step_reg   <= '0;
        end
        if (cmd.sqrt_step)
        begin
            sq_x_reg   <= {sq_x_reg[SQ_W-3:0], 2'b00};
            sq_rem_reg <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
            root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
            step_reg   <= step_reg + 1'b1;
        end
        if (cmd.norm_latch)
        begin
            norm_reg   <= (root_ext >= floor_ext) ? root_ext : floor_ext;
            rd_idx_reg <= '0;
        end
        if (cmd.next_elem)
        begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            dvd_reg  <= {rd_mag, FRAC_SHIFT'(0)};
            neg_reg  <= rd_data_reg[SAMPLE_BITS-1];
            rem_reg  <= '0;
            q_reg    <= '0;
            sat_reg  <= 1'b0;
            step_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg  <= div_ge ? div_diff[NORM_W-1:0] : div_rem_sh[NORM_W-1:0];
            q_reg    <= {q_reg[QUO_W-2:0], div_ge};
            sat_reg  <= sat_reg | q_reg[QUO_W-1];
            step_reg <= step_reg + 1'b1;
        end
    end

    // Result register, loaded after the last quotient bit.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unit_value <= val;
            last_res   <= sts.is_last_elem;
            overflow   <= overflowed_reg;
        end
    end

endmodule

// ===== hdl/vector_l2_normalize.sv =====
// Top level of the vector L2 normalization block.
`timescale 1ns / 1ps

// Vector L2 normalization. Signed Q4.12 elements stream in one per transfer, the final
// element marked by last; each is stored and its square is added to a running sum, one
// element per cycle. After the final element the block takes the floor integer square
// root of the sum (one root bit per cycle), raises it to norm_floor (a floor of 0 acts
// as 1), and then emits every stored element divided by that norm as signed Q1.15,
// saturated, with last_res on the final result and overflow on every result of a
// vector that held more than MAX_LEN elements (the extra elements are dropped). Each
// result comes from a bit-serial divider, and the next element is read only after the
// receiver takes the current result. The input is stalled from the final element
// until the last result transfer of that vector. norm_floor is written through
// cfg_wr_en / cfg_wr_data while the block is idle.
module vector_l2_normalize
    import vl2n_pkg::*;
#(
    parameter int MAX_LEN     = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_W-1:0]       unit_value,
    output logic                          last_res,
    output logic                          overflow,
    input  logic                          cfg_wr_en,
    input  logic [FLOOR_W-1:0]            cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    vl2n_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    vl2n_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .sample      (sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .unit_value  (unit_value),
        .last_res    (last_res),
        .overflow    (overflow)
    );

endmodule

// ===== hdl/vl2n_checker.sv =====
// Port-level checker for the vector L2 normalization block, with its bind.
`timescale 1ns / 1ps

module vl2n_checker
    import vl2n_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [OUT_W-1:0] unit_value,
    input logic             last_res
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(unit_value) && $stable(last_res))
        else $error("result changed while stalled");

    // No input transfer while a result is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
        else $error("input taken while emitting");

    // After the final result of a vector the block returns to loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_res |=> !out_valid && !in_stall)
        else $error("no return to loading after final result");

endmodule

bind vector_l2_normalize vl2n_checker u_vl2n_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .unit_value (unit_value),
    .last_res   (last_res)
);

// ===== verif/vector_l2_normalize_tb.sv =====
// Self-checking testbench for the vector L2 normalization block.
`timescale 1ns / 1ps

module vector_l2_normalize_tb;
    import vl2n_pkg::*;

    localparam int VEC_DEPTH = 64;

    // One element offered to the block: its value and the end-of-vector mark.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } element_t;

    // One normalized element that the block should produce.
    typedef struct packed {
        logic signed [15:0] unit_value;
        logic               last_res;
        logic               overflow;
    } unit_elem_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [15:0]   sample;
    logic                 last;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [15:0]   unit_value;
    logic                 last_res;
    logic                 overflow;
    logic                 cfg_wr_en;
    logic [FLOOR_W-1:0]   cfg_wr_data;

    vector_l2_normalize dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .unit_value (unit_value),
        .last_res   (last_res),
        .overflow   (overflow),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Elements that are still waiting to be driven.
    element_t   pending_elems[$];
    // Normalized elements that are predicted but not yet seen.
    unit_elem_t expected_units[$];

    // Shadow copy of the block state, used to predict its output.
    logic [FLOOR_W-1:0]  shadow_floor;
    logic signed [15:0]  shadow_store[VEC_DEPTH];
    int                  shadow_count;
    logic [36:0]         shadow_sum;
    bit                  shadow_over;

    int  error_count;
    int  elems_accepted;
    int  units_checked;
    int  vectors_done;
    int  overflow_vectors;
    bit  hold_off_req;
    bit  hold_off_done;
    int  hold_cycles;
    bit  sender_enable;
    bit  in_accepted;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Floor integer square root, one result bit per loop pass.
    function automatic logic [36:0] int_sqrt(input logic [36:0] radicand);
        logic [36:0] root;
        logic [36:0] trial;
        root = '0;
        for (int b = 18; b >= 0; b--) begin
            trial = root | (37'd1 << b);
            if (64'(trial) * 64'(trial) <= 64'(radicand))
                root = trial;
        end
        return root;
    endfunction

    // Update the shadow state with one accepted element and queue any normalized output.
    task automatic predict_normalize(input element_t elem);
        logic [15:0] mag;
        logic [36:0] norm;
        logic [36:0] floor_v;
        logic [36:0] quo;
        logic [15:0] val;
        bit          neg;
        if (shadow_count < VEC_DEPTH) begin
            mag = elem.sample[15] ? 16'(-elem.sample) : elem.sample;
            shadow_store[shadow_count] = elem.sample;
            shadow_count++;
            shadow_sum += 37'(mag) * 37'(mag);
        end else begin
            shadow_over = 1'b1;
        end
        if (!elem.last)
            return;
        norm = int_sqrt(shadow_sum);
        floor_v = (shadow_floor == 0) ? 37'd1 : 37'(shadow_floor);
        if (norm < floor_v)
            norm = floor_v;
        for (int i = 0; i < shadow_count; i++) begin
            neg = shadow_store[i][15];
            mag = neg ? 16'(-shadow_store[i]) : shadow_store[i];
            quo = (37'(mag) << FRAC_SHIFT) / norm;
            if (neg) begin
                if (quo > 37'd32768)
                    quo = 37'd32768;
                val = 16'(17'h10000 - 17'(quo));
            end else begin
                if (quo > 37'd32767)
                    quo = 37'd32767;
                val = quo[15:0];
            end
            expected_units.push_back('{val, i == shadow_count - 1, shadow_over});
        end
        if (shadow_over)
            overflow_vectors++;
        vectors_done++;
        shadow_count = 0;
        shadow_sum = '0;
        shadow_over = 1'b0;
    endtask

    // Sender: offers elements in bursts of random length with random gaps.
    int burst_left;
    int gap_left;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_accepted) begin
                void'(pending_elems.pop_front());
            end
            if (in_valid && !in_accepted) begin
                // hold the stalled element steady
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (sender_enable && pending_elems.size() > 0) begin
                in_valid <= 1'b1;
                sample   <= pending_elems[0].sample;
                last     <= pending_elems[0].last;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 30);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Record the prediction at the same edge the block accepts the element.
    always @(posedge clk) begin
        in_accepted = rst_n && in_valid && !in_stall;
        if (in_accepted) begin
            predict_normalize('{sample, last});
            elems_accepted++;
        end
    end

    // Receiver stall pattern: quiet stretches, random stalls, and one long hold-off.
    int stall_mode;
    int stall_left;
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_off_req && !hold_off_done) begin
                out_stall <= 1'b1;
                hold_cycles++;
                if (hold_cycles >= 600)
                    hold_off_done = 1'b1;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(5, 80);
                end else begin
                    stall_left--;
                end
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 7) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: compares every result transfer against the oldest prediction.
    unit_elem_t got_unit;
    unit_elem_t want_unit;
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got_unit = '{unit_value, last_res, overflow};
            if (expected_units.size() == 0) begin
                $display("%0t unexpected result: actual %p", $realtime, got_unit);
                error_count++;
            end else begin
                want_unit = expected_units.pop_front();
                if (got_unit.unit_value !== want_unit.unit_value) begin
                    $display("%0t unit_value mismatch: expected %0d actual %0d", $realtime,
                             want_unit.unit_value, got_unit.unit_value);
                    error_count++;
                end
                if (got_unit.last_res !== want_unit.last_res) begin
                    $display("%0t last_res mismatch: expected %0b actual %0b", $realtime,
                             want_unit.last_res, got_unit.last_res);
                    error_count++;
                end
                if (got_unit.overflow !== want_unit.overflow) begin
                    $display("%0t overflow mismatch: expected %0b actual %0b", $realtime,
                             want_unit.overflow, got_unit.overflow);
                    error_count++;
                end
                units_checked++;
            end
        end
    end

    // Random element value; sizes vary to cover small values and the extremes.
    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 15)) - 16'sd8;
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return 16'($urandom_range(0, 8191)) - 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one vector of the given length, with random content.
    task automatic queue_vector(input int len);
        for (int i = 0; i < len; i++)
            pending_elems.push_back('{rand_sample(), i == len - 1});
    endtask

    // Wait until every queued element is accepted and every result is seen.
    task automatic drain();
        while (pending_elems.size() > 0 || in_valid || expected_units.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Write the norm floor register while the block is idle.
    task automatic write_floor(input logic [FLOOR_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        shadow_floor = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    int sent_count;
    int vec_len;
    logic [FLOOR_W-1:0] floor_choices[6];

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        last = 1'b0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        shadow_floor = 19'd1;
        shadow_count = 0;
        shadow_sum = '0;
        shadow_over = 1'b0;
        error_count = 0;
        elems_accepted = 0;
        units_checked = 0;
        vectors_done = 0;
        overflow_vectors = 0;
        hold_off_req = 1'b0;
        hold_off_done = 1'b0;
        hold_cycles = 0;
        sender_enable = 1'b1;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        stall_left = 0;
        floor_choices = '{19'd0, 19'd1, 19'd4096, 19'd20000, 19'd262144, 19'h7FFFF};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset floor: extremes, single elements, full scale.
        pending_elems.push_back('{16'sh7FFF, 1'b1});   // full-scale positive, quotient 1.0
        pending_elems.push_back('{16'sh8000, 1'b1});   // full-scale negative
        pending_elems.push_back('{16'sh0000, 1'b1});   // all-zero vector, floor takes over
        pending_elems.push_back('{16'sh7FFF, 1'b0});
        pending_elems.push_back('{16'sh8000, 1'b0});
        pending_elems.push_back('{16'shFFFF, 1'b0});
        pending_elems.push_back('{16'sh0001, 1'b1});
        pending_elems.push_back('{16'sh5555, 1'b0});
        pending_elems.push_back('{16'shAAAA, 1'b1});
        drain();

        // A zero floor must act as one; a large floor shrinks every result.
        write_floor(19'd0);
        pending_elems.push_back('{16'sh0003, 1'b0});
        pending_elems.push_back('{16'shFFFD, 1'b1});
        drain();
        write_floor(19'h7FFFF);
        pending_elems.push_back('{16'sh7FFF, 1'b0});
        pending_elems.push_back('{16'sh8000, 1'b1});
        drain();
        write_floor(19'd1);

        // An over-long vector: the extra elements, the final one among them, are dropped.
        queue_vector(VEC_DEPTH + 3);
        sent_count = VEC_DEPTH + 3;

        // Long receiver hold-off while the sender keeps offering, so the block backs up.
        hold_off_req = 1'b1;
        queue_vector(5);
        queue_vector(4);
        wait (hold_off_done);
        hold_off_req = 1'b0;
        drain();
        sent_count += 9;

        // Random phases, each under its own floor; mostly short vectors.
        for (int phase = 0; sent_count < 480; phase++) begin
            write_floor(phase < 6 ? floor_choices[phase] : 19'($urandom_range(1, 262144)));
            for (int v = 0; v < 8 && sent_count < 480; v++) begin
                case ($urandom_range(0, 9))
                    0: vec_len = $urandom_range(VEC_DEPTH - 2, VEC_DEPTH + 4);
                    1: vec_len = 1;
                    default: vec_len = $urandom_range(2, 12);
                endcase
                queue_vector(vec_len);
                sent_count += vec_len;
            end
            drain();
        end

        $display("Checked %0d results from %0d vectors (%0d truncated), %0d elements accepted.",
                 units_checked, vectors_done, overflow_vectors, elems_accepted);
        if (error_count == 0)
            $display("PASS vector_l2_normalize");
        else
            $display("FAIL vector_l2_normalize");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #3000000;
        $display("FAIL vector_l2_normalize");
        $finish;
    end

endmodule
